[rtl/vrt_pkg.sv]
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the vector rank unit: controller states,
// command and status bundles, field widths and register codes.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int RANK_W     = 8;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TIES = 2'd2;

    // Tie handling codes
    localparam logic [1:0] TIE_AVERAGE = 2'd0;
    localparam logic [1:0] TIE_MIN     = 2'd1;
    localparam logic [1:0] TIE_MAX     = 2'd2;
    localparam logic [1:0] TIE_FIRST   = 2'd3;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_LATCH,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;   // store the accepted sample
        logic fetch;  // read the element being ranked
        logic start;  // latch its value, clear the counters
        logic scan;   // read the next element to compare
        logic emit;   // load the result register, advance
    } t_cmd;

    typedef struct packed {
        logic full;       // the store fills with this request
        logic scan_done;  // every element has been read
        logic last_elem;  // the element being ranked is the final one
        logic out_free;   // the result register can take a new result
    } t_sts;

endpackage

[rtl/vector_rank_with_ties_unit.sv]
// ----------------------------------------------------------------------------
// vector_rank_with_ties_unit
// Ranks a vector of signed samples, with average, min, max or first handling
// of ties, and returns twice each rank in original order.
// ----------------------------------------------------------------------------
// Samples are accepted one per cycle until one marked last arrives (or the
// store holds MAX_LEN values); the input then stalls while the vector is
// ranked. Each element is compared against the whole vector through one
// comparator fed by the single read port of the value store; the input opens
// again once the final result is loaded into the result register. Results
// come out in original order through a result register; the final one
// carries final_res, and the next vector may load while it waits to be
// taken. Configuration writes are always ready and take effect at once, so
// write them between vectors or while a vector is loading.
module vector_rank_with_ties_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [vrt_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic                                i_in_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [vrt_pkg::RANK_W-1:0]          o_out_rank_twice,
    output logic [vrt_pkg::POS_W-1:0]           o_out_position,
    output logic                                o_out_final_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vrt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    vrt_pkg::t_cmd cmd;
    vrt_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    vrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vrt_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_sample      (i_in_sample),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_rank_twice (o_out_rank_twice),
        .o_out_position   (o_out_position),
        .o_out_final_res  (o_out_final_res)
    );

endmodule

[rtl/vrt_ctrl.sv]
// ----------------------------------------------------------------------------
// vrt_ctrl
// Controller of the vector rank unit: loads requests, then walks each element
// through fetch, compare sweep and result emission.
// ----------------------------------------------------------------------------
module vrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_stall,
    input  vrt_pkg::t_sts i_sts,
    output vrt_pkg::t_cmd o_cmd
);

    vrt_pkg::t_state r_state;
    vrt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrt_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            vrt_pkg::S_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // a full store ends the vector whatever the last bit says
                    if (i_in_last || i_sts.full) begin
                        n_state = vrt_pkg::S_FETCH;
                    end
                end
            end
            vrt_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = vrt_pkg::S_LATCH;
            end
            vrt_pkg::S_LATCH: begin
                o_cmd.start = 1'b1;
                n_state     = vrt_pkg::S_SCAN;
            end
            vrt_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = vrt_pkg::S_EMIT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            vrt_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last_elem ? vrt_pkg::S_LOAD : vrt_pkg::S_FETCH;
                end
            end
            default: begin
                n_state = vrt_pkg::S_LOAD;
            end
        endcase
    end

endmodule

[rtl/vrt_dp.sv]
// ----------------------------------------------------------------------------
// vrt_dp
// Datapath of the vector rank unit: value store, shared comparator with its
// counters, rank arithmetic, result register and configuration registers.
// ----------------------------------------------------------------------------
module vrt_dp #(
    parameter int MAX_LEN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [vrt_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic                                i_cfg_valid,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vrt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  vrt_pkg::t_cmd                       i_cmd,
    output vrt_pkg::t_sts                       o_sts,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [vrt_pkg::RANK_W-1:0]          o_out_rank_twice,
    output logic [vrt_pkg::POS_W-1:0]           o_out_position,
    output logic                                o_out_final_res
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int RW = (CW + 2 > vrt_pkg::RANK_W) ? CW + 2 : vrt_pkg::RANK_W;
    localparam int PW = (AW > vrt_pkg::POS_W) ? AW : vrt_pkg::POS_W;

    logic signed [vrt_pkg::SAMPLE_W-1:0] mem [MAX_LEN];

    logic [1:0]                          r_tie_mode;
    logic                                r_descending;
    logic [CW-1:0]                       r_fill;
    logic [AW-1:0]                       r_i;
    logic [CW-1:0]                       r_j;
    logic signed [vrt_pkg::SAMPLE_W-1:0] r_v;
    logic signed [vrt_pkg::SAMPLE_W-1:0] r_rd;
    logic                                r_rd_vld;
    logic [AW-1:0]                       r_rd_idx;
    logic [CW-1:0]                       r_less;
    logic [CW-1:0]                       r_eq;
    logic [CW-1:0]                       r_before;
    logic                                r_out_vld;
    logic [vrt_pkg::RANK_W-1:0]          r_rank;
    logic [vrt_pkg::POS_W-1:0]           r_pos;
    logic                                r_final;

    logic [AW-1:0] rd_addr;
    logic          is_eq;
    logic          is_ahead;
    logic [RW-1:0] rank;
    logic [PW-1:0] pos;
    logic          cfg_wr;

    assign cfg_wr  = i_cfg_valid;
    assign rd_addr = i_cmd.fetch ? r_i : r_j[AW-1:0];
    assign is_eq   = (r_rd == r_v);
    assign is_ahead = r_descending ? (r_rd > r_v) : (r_rd < r_v);

    assign o_sts.full      = (r_fill == CW'(MAX_LEN - 1));
    assign o_sts.scan_done = (r_j == r_fill);
    assign o_sts.last_elem = ((CW'(r_i) + CW'(1)) == r_fill);
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

    always_comb begin
        unique case (r_tie_mode)
            vrt_pkg::TIE_AVERAGE: rank = (RW'(r_less) << 1) + RW'(r_eq) + RW'(1);
            vrt_pkg::TIE_MIN:     rank = (RW'(r_less) + RW'(1)) << 1;
            vrt_pkg::TIE_MAX:     rank = (RW'(r_less) + RW'(r_eq)) << 1;
            vrt_pkg::TIE_FIRST:   rank = (RW'(r_less) + RW'(r_before) + RW'(1)) << 1;
            default:              rank = '0;
        endcase
    end

    assign pos = PW'(r_i);

    // Store and registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[r_fill[AW-1:0]] <= i_in_sample;
        end
        r_rd <= mem[rd_addr];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_j[AW-1:0];
        if (i_cmd.start) begin
            r_v <= r_rd;
        end
        if (i_cmd.emit) begin
            r_rank  <= rank[vrt_pkg::RANK_W-1:0];
            r_pos   <= pos[vrt_pkg::POS_W-1:0];
            r_final <= o_sts.last_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tie_mode   <= vrt_pkg::TIE_AVERAGE;
            r_descending <= 1'b0;
            r_fill       <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_rd_vld     <= 1'b0;
            r_less       <= '0;
            r_eq         <= '0;
            r_before     <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            // the stable flag has no storage; writes to its index are ignored
            if (cfg_wr) begin
                if (i_cfg_index == vrt_pkg::CFG_TIE_MODE) begin
                    r_tie_mode <= i_cfg_data;
                end else if (i_cfg_index == vrt_pkg::CFG_DESCENDING) begin
                    r_descending <= i_cfg_data[0];
                end
            end

            if (i_cmd.load) begin
                r_fill <= r_fill + CW'(1);
            end

            r_rd_vld <= i_cmd.scan;
            if (i_cmd.scan) begin
                r_j <= r_j + CW'(1);
            end

            if (i_cmd.start) begin
                r_j      <= '0;
                r_less   <= '0;
                r_eq     <= '0;
                r_before <= '0;
            end else if (r_rd_vld) begin
                if (is_eq) begin
                    r_eq <= r_eq + CW'(1);
                    if (r_rd_idx < r_i) begin
                        r_before <= r_before + CW'(1);
                    end
                end else if (is_ahead) begin
                    r_less <= r_less + CW'(1);
                end
            end

            if (i_cmd.emit) begin
                if (o_sts.last_elem) begin
                    r_i    <= '0;
                    r_j    <= '0;
                    r_fill <= '0;
                end else begin
                    r_i <= r_i + AW'(1);
                end
            end

            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_out_rank_twice = r_rank;
    assign o_out_position   = r_pos;
    assign o_out_final_res  = r_final;

`ifndef SYNTHESIS
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_vld || !i_out_stall))
        else $error("result overwritten while stalled");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_rd_vld && r_i == '0))
        else $error("sample stored during ranking");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j <= r_fill)
        else $error("compare sweep ran past the fill count");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_sts.last_elem) |=> (r_fill == '0 && r_i == '0))
        else $error("vector not cleared after final result");
`endif

endmodule

[dv/vector_rank_with_ties_unit_tb.sv]
// ----------------------------------------------------------------------------
// vector_rank_with_ties_unit_tb
// Self-checking bench for the vector rank unit. Vectors of signed samples are
// streamed in, the expected doubled ranks are worked out per element in a
// scoreboard, and each result is compared with the oldest expected rank.
// Tie modes and order are changed between vectors; both sides stall at random.
// ----------------------------------------------------------------------------
class rank_scoreboard;
    typedef struct packed {
        logic [vrt_pkg::RANK_W-1:0] rank_twice;
        logic [vrt_pkg::POS_W-1:0]  position;
        logic                       final_res;
    } t_rank_result;

    int                                  max_len;
    logic signed [vrt_pkg::SAMPLE_W-1:0] values[];
    int                                  fill;
    logic [1:0]                          tie_mode;
    logic                                descending;
    logic                                stable_ties;
    t_rank_result                        ranks_due[$];
    int                                  errors;

    function new(int n);
        max_len     = n;
        values      = new[n];
        fill        = 0;
        tie_mode    = vrt_pkg::TIE_AVERAGE;
        descending  = 1'b0;
        stable_ties = 1'b1;
        errors      = 0;
    endfunction

    function void write_reg(logic [vrt_pkg::CFG_IDX_W-1:0] idx,
                            logic [vrt_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            vrt_pkg::CFG_TIE_MODE:    tie_mode = data;
            vrt_pkg::CFG_DESCENDING:  descending = data[0];
            vrt_pkg::CFG_STABLE_TIES: stable_ties = data[0];
            default: ;
        endcase
    endfunction

    function int pending();
        return ranks_due.size();
    endfunction

    function logic [vrt_pkg::RANK_W-1:0] rank_of(int idx, int n);
        int lower;
        int equal;
        int earlier;
        int r;
        lower   = 0;
        equal   = 0;
        earlier = 0;
        for (int j = 0; j < n; j++) begin
            if (values[j] == values[idx]) begin
                equal++;
                if (j < idx)
                    earlier++;
            end else if (descending ? (values[j] > values[idx]) : (values[j] < values[idx])) begin
                lower++;
            end
        end
        case (tie_mode)
            vrt_pkg::TIE_AVERAGE: r = 2 * lower + equal + 1;
            vrt_pkg::TIE_MIN:     r = 2 * (lower + 1);
            vrt_pkg::TIE_MAX:     r = 2 * (lower + equal);
            default:              r = 2 * (lower + earlier + 1);
        endcase
        return r[vrt_pkg::RANK_W-1:0];
    endfunction

    function void note_sample(logic [vrt_pkg::SAMPLE_W-1:0] sample, logic last);
        t_rank_result r;
        int n;
        if (fill >= max_len)
            fill = 0;
        values[fill] = sample;
        fill++;
        // a full store closes the vector whatever the last bit says
        if (!last && fill < max_len)
            return;
        n = fill;
        for (int i = 0; i < n; i++) begin
            r.rank_twice = rank_of(i, n);
            r.position   = i[vrt_pkg::POS_W-1:0];
            r.final_res  = (i == n - 1);
            ranks_due.push_back(r);
        end
        fill = 0;
    endfunction

    function void check_result(logic [vrt_pkg::RANK_W-1:0] rank,
                               logic [vrt_pkg::POS_W-1:0] pos, logic fin);
        t_rank_result want;
        if (ranks_due.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: rank_twice %0d position %0d",
                     $time, rank, pos);
            return;
        end
        want = ranks_due.pop_front();
        if (rank !== want.rank_twice) begin
            errors++;
            $display("%0t: rank_twice mismatch: expected %0d, got %0d",
                     $time, want.rank_twice, rank);
        end
        if (pos !== want.position) begin
            errors++;
            $display("%0t: position mismatch: expected %0d, got %0d",
                     $time, want.position, pos);
        end
        if (fin !== want.final_res) begin
            errors++;
            $display("%0t: final_res mismatch: expected %0d, got %0d",
                     $time, want.final_res, fin);
        end
    endfunction
endclass

module vector_rank_with_ties_unit_tb;

    localparam int                            VEC_MAX    = 64;
    localparam logic [vrt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic signed [vrt_pkg::SAMPLE_W-1:0] i_in_sample;
    logic                                i_in_last;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [vrt_pkg::RANK_W-1:0]          o_out_rank_twice;
    logic [vrt_pkg::POS_W-1:0]           o_out_position;
    logic                                o_out_final_res;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [vrt_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [vrt_pkg::CFG_DATA_W-1:0]      i_cfg_data;

    int src_gap_pct  = 0;
    int sink_gap_pct = 0;
    int items_sent   = 0;

    rank_scoreboard sb = new(VEC_MAX);

    vector_rank_with_ties_unit #(
        .MAX_LEN(VEC_MAX)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_sample     (i_in_sample),
        .i_in_last       (i_in_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_rank_twice(o_out_rank_twice),
        .o_out_position  (o_out_position),
        .o_out_final_res (o_out_final_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_gap_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_rank_twice, o_out_position, o_out_final_res);
    end

    initial begin
        #2_000_000;
        $display("vector_rank_with_ties_unit_tb NOT OK");
        $finish;
    end

    // All tasks start and end just after a falling edge.
    task automatic send_item(input logic [vrt_pkg::SAMPLE_W-1:0] sample, input logic last);
        while ($urandom_range(99) < src_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_in_sample = sample;
        i_in_last   = last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(sample, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold off until every rank is out and the block has settled.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [vrt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vrt_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_tie_probe();
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(-32'sd3, 1'b0);
        send_item(32'sd5, 1'b1);
    endtask

    task automatic send_vector(input int len, input bit tied, input bit mark_last);
        logic [vrt_pkg::SAMPLE_W-1:0] pool[4];
        for (int k = 0; k < 4; k++)
            pool[k] = $urandom();
        if ($urandom_range(3) == 0)
            pool[0] = 32'h8000_0000;
        if ($urandom_range(3) == 0)
            pool[1] = 32'h7fff_ffff;
        for (int k = 0; k < len; k++)
            send_item(tied ? pool[$urandom_range(3)] : $urandom(), mark_last && (k == len - 1));
    endtask

    initial begin
        int start;
        int len;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_sample = '0;
        i_in_last   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = vrt_pkg::CFG_TIE_MODE;
        i_cfg_data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: extremes, single element, every tie mode
        src_gap_pct  = 16;
        sink_gap_pct = 69;
        cfg_write(vrt_pkg::CFG_TIE_MODE, vrt_pkg::TIE_AVERAGE);
        cfg_write(vrt_pkg::CFG_DESCENDING, 2'd0);
        cfg_write(vrt_pkg::CFG_STABLE_TIES, 2'd0);
        cfg_write(CFG_UNUSED, 2'd3);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h7fff_ffff, 1'b1);
        wait_idle();
        cfg_write(vrt_pkg::CFG_TIE_MODE, vrt_pkg::TIE_MIN);
        cfg_write(vrt_pkg::CFG_DESCENDING, 2'd3);
        send_tie_probe();
        wait_idle();
        cfg_write(vrt_pkg::CFG_TIE_MODE, vrt_pkg::TIE_MAX);
        cfg_write(vrt_pkg::CFG_DESCENDING, 2'd2);
        cfg_write(vrt_pkg::CFG_STABLE_TIES, 2'd1);
        send_tie_probe();
        wait_idle();
        cfg_write(vrt_pkg::CFG_TIE_MODE, vrt_pkg::TIE_FIRST);
        cfg_write(vrt_pkg::CFG_DESCENDING, 2'd1);
        send_tie_probe();

        // random: receiver-heavy gaps, then sender-heavy, then none
        for (int phase = 0; phase < 3; phase++) begin
            src_gap_pct  = (phase == 0) ? 16 : (phase == 1) ? 69 : 0;
            sink_gap_pct = (phase == 0) ? 69 : (phase == 1) ? 16 : 0;
            wait_idle();
            cfg_write(vrt_pkg::CFG_TIE_MODE, 2'($urandom_range(3)));
            cfg_write(vrt_pkg::CFG_DESCENDING, 2'($urandom_range(3)));
            cfg_write(vrt_pkg::CFG_STABLE_TIES, 2'($urandom_range(3)));
            start = items_sent;
            while (items_sent - start < 30) begin
                if ($urandom_range(3) == 0) begin
                    wait_idle();
                    cfg_write(2'($urandom_range(3)), 2'($urandom_range(3)));
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
                send_vector(len, $urandom_range(2) != 0, 1'b1);
            end
            // fill the store with no last bit: the final sample must close it
            if (phase == 0)
                send_vector(VEC_MAX, 1'b1, 1'b0);
        end

        i_in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (64) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("vector_rank_with_ties_unit_tb OK");
        else
            $display("vector_rank_with_ties_unit_tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/vrt_pkg.sv
rtl/vrt_ctrl.sv
rtl/vrt_dp.sv
rtl/vector_rank_with_ties_unit.sv
dv/vector_rank_with_ties_unit_tb.sv
